// File: hw/rtl/cds_pkg.sv
// Shared constants, command and status types, and a calendar helper for the date shifter.
`timescale 1ns / 1ps

package cds_pkg;

	localparam int OFFSET_BITS = 17;
	localparam int DAY_W       = 5;
	localparam int MONTH_W     = 4;
	localparam int YEAR_W      = 14;

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
	localparam logic [YEAR_W-1:0]  YEAR_MIN   = YEAR_W'(1);
	localparam logic [YEAR_W-1:0]  YEAR_CYCLE = YEAR_W'(400);
	localparam logic [YEAR_W-1:0]  CENTURY_1  = YEAR_W'(100);
	localparam logic [YEAR_W-1:0]  CENTURY_2  = YEAR_W'(200);
	localparam logic [YEAR_W-1:0]  CENTURY_3  = YEAR_W'(300);
	localparam logic [YEAR_W-1:0]  CYCLE_LAST = YEAR_W'(399);

	localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
	localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
	localparam logic [DAY_W-1:0]   DAY_LAST   = DAY_W'(31);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture a new transaction
		logic reduce;     // one subtraction of 400 from the year residue
		logic step;       // move the date by one day
		logic set_range;  // mark that a year limit stopped the walk
		logic set_bad;    // mark the input date as invalid
		logic out_load;   // copy the working date into the output register
	} cds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rem_ge_cycle;  // year residue still at or above 400
		logic date_ok;       // the captured date is a valid one
		logic count_zero;    // no days left to move
		logic at_limit;      // the next step would leave the year range
	} cds_status_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:                       len = leap ? DAY_W'(29) : DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11:    len = DAY_W'(30);
			default:                    len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

// File: hw/rtl/cds_datapath.sv
// Datapath of the date shifter: working date, year residue, day counter and output register.
`timescale 1ns / 1ps

module cds_datapath
	import cds_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  cds_cmd_t                     cmd,
	output cds_status_t                  status,
	input  logic [DAY_W-1:0]             in_day,
	input  logic [MONTH_W-1:0]           in_month,
	input  logic [YEAR_W-1:0]            in_year,
	input  logic signed [OFFSET_BITS-1:0] day_offset,
	output logic [DAY_W-1:0]             out_day,
	output logic [MONTH_W-1:0]           out_month,
	output logic [YEAR_W-1:0]            out_year,
	output logic                         range_flag,
	output logic                         bad_date
);

	logic [DAY_W-1:0]       day_q;
	logic [MONTH_W-1:0]     month_q;
	logic [YEAR_W-1:0]      year_q;
	logic [YEAR_W-1:0]      rem_q;
	logic [OFFSET_BITS-1:0] count_q;
	logic                   back_q;
	logic                   range_q;
	logic                   bad_q;

	logic                   leap;
	logic [DAY_W-1:0]       len_cur;
	logic [DAY_W-1:0]       len_prev;
	logic [MONTH_W-1:0]     month_prev;
	logic [OFFSET_BITS-1:0] offset_mag;

	// The residue is the year modulo 400 once reduction is done, so the leap
	// test needs only its low bits and three century compares.
	assign leap = (rem_q[1:0] == 2'b00) && (rem_q != CENTURY_1) &&
		(rem_q != CENTURY_2) && (rem_q != CENTURY_3);
	assign month_prev = month_q - MONTH_W'(1);
	assign len_cur    = month_len(month_q, leap);
	assign len_prev   = month_len(month_prev, leap);
	assign offset_mag = day_offset[OFFSET_BITS-1] ? (~day_offset + OFFSET_BITS'(1)) :
		day_offset;

	assign status.rem_ge_cycle = (rem_q >= YEAR_CYCLE);
	assign status.date_ok = (month_q >= MONTH_JAN) && (month_q <= MONTH_DEC) &&
		(day_q != '0) && (day_q <= len_cur) && (year_q != '0) && (year_q <= YEAR_MAX);
	assign status.count_zero = (count_q == '0);
	assign status.at_limit = back_q ?
		((day_q == DAY_FIRST) && (month_q == MONTH_JAN) && (year_q == YEAR_MIN)) :
		((day_q == DAY_LAST) && (month_q == MONTH_DEC) && (year_q == YEAR_MAX));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= in_day;
			month_q <= in_month;
			year_q  <= in_year;
			rem_q   <= in_year;
			count_q <= offset_mag;
			back_q  <= day_offset[OFFSET_BITS-1];
		end else if (cmd.reduce) begin
			rem_q <= rem_q - YEAR_CYCLE;
		end else if (cmd.step) begin
			count_q <= count_q - OFFSET_BITS'(1);
			if (!back_q) begin
				if (day_q == len_cur) begin
					day_q <= DAY_FIRST;
					if (month_q == MONTH_DEC) begin
						month_q <= MONTH_JAN;
						year_q  <= year_q + YEAR_W'(1);
						rem_q   <= (rem_q == CYCLE_LAST) ? '0 : rem_q + YEAR_W'(1);
					end else begin
						month_q <= month_q + MONTH_W'(1);
					end
				end else begin
					day_q <= day_q + DAY_W'(1);
				end
			end else begin
				if (day_q == DAY_FIRST) begin
					if (month_q == MONTH_JAN) begin
						day_q   <= DAY_LAST;
						month_q <= MONTH_DEC;
						year_q  <= year_q - YEAR_W'(1);
						rem_q   <= (rem_q == '0) ? CYCLE_LAST : rem_q - YEAR_W'(1);
					end else begin
						day_q   <= len_prev;
						month_q <= month_prev;
					end
				end else begin
					day_q <= day_q - DAY_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= 1'b0;
			bad_q   <= 1'b0;
		end else if (cmd.load) begin
			range_q <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			if (cmd.set_range) begin
				range_q <= 1'b1;
			end
			if (cmd.set_bad) begin
				bad_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_day    <= day_q;
			out_month  <= month_q;
			out_year   <= year_q;
			range_flag <= range_q;
			bad_date   <= bad_q;
		end
	end

endmodule

// File: hw/rtl/cds_ctrl.sv
// Controller of the date shifter: sequences reduction, validation, day stepping and output.
`timescale 1ns / 1ps

module cds_ctrl
	import cds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  cds_status_t status,
	output cds_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.load = in_valid && in_ready_q;
			ST_REDUCE: cmd.reduce = status.rem_ge_cycle;
			ST_CHECK:  cmd.set_bad = !status.date_ok;
			ST_RUN: begin
				if (!status.count_zero) begin
					if (status.at_limit) begin
						cmd.set_range = 1'b1;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			ST_FINISH: cmd.out_load = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// A result loaded in this cycle replaces the one leaving, if any.
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (!status.rem_ge_cycle) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= status.date_ok ? ST_RUN : ST_FINISH;
				end
				ST_RUN: begin
					if (status.count_zero || status.at_limit) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						in_ready_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/calendar_date_shift_core.sv
// Top level of the Gregorian date shifter: controller and datapath joined by command and status.
`timescale 1ns / 1ps

// Shifts a Gregorian date by a signed number of days, walking one day per
// clock cycle, and returns one result transaction per input transaction.
// After an input transaction is accepted the block first reduces the year to
// its residue modulo 400 by repeated subtraction, one subtraction per cycle,
// until the residue is below 400. It then validates the date, steps the date
// once per day of the offset magnitude until the count runs out, and loads
// the output register. The result appears in the same cycle as in_ready
// rises again, so the next input transaction can be accepted as soon as the
// result appears; for long offsets the single day-step unit dominates the
// cost of a shift. An invalid date (month outside 1 to 12, day zero or beyond
// its month, year zero or above 9999) skips the walk and is returned
// unchanged with bad_date set. A walk that would pass 31 December 9999 or
// 1 January of year 1 stops on that date with range_flag set; landing
// exactly on it does not set the flag. The result sits in an output
// register, so the next input transaction is taken while a finished result
// still waits for out_ready.
module calendar_date_shift_core
	import cds_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [DAY_W-1:0]              in_day,
	input  logic [MONTH_W-1:0]            in_month,
	input  logic [YEAR_W-1:0]             in_year,
	input  logic signed [OFFSET_BITS-1:0] day_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DAY_W-1:0]              out_day,
	output logic [MONTH_W-1:0]            out_month,
	output logic [YEAR_W-1:0]             out_year,
	output logic                          range_flag,
	output logic                          bad_date
);

	cds_cmd_t    cmd;
	cds_status_t status;

	// The controller owns the handshakes and decides what the datapath does
	// in each cycle.
	cds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the working date, the day counter and the result.
	cds_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_day     (in_day),
		.in_month   (in_month),
		.in_year    (in_year),
		.day_offset (day_offset),
		.out_day    (out_day),
		.out_month  (out_month),
		.out_year   (out_year),
		.range_flag (range_flag),
		.bad_date   (bad_date)
	);

endmodule

// File: tb/calendar_date_shift_core_tb.sv
// Self-checking testbench for the date shifter: directed calendar corners, then random walks.
`timescale 1ns / 1ps

// The testbench drives dates and signed day offsets into the core through a
// valid/ready channel. It checks every result transaction against a
// date-arithmetic predictor that is kept inside this module. Every accepted
// input transaction pushes one predicted result onto a queue. Every accepted
// output transaction pops the oldest prediction and compares it field by
// field. Inputs change on the falling edge of the clock. Handshakes and
// outputs are sampled on the rising edge. This keeps the sampling free of
// races with the core's own flops.
module calendar_date_shift_core_tb;
	import cds_pkg::*;

	// The core walks one day per cycle, so the longest silent stretch is the
	// largest offset the bench sends (65535 days) plus year reduction, output stalls and
	// input gaps. The watchdog allows several times that.
	localparam int QUIET_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 1130;

	// One predicted result transaction.
	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               range_hit;
		logic               invalid;
	} shifted_date_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          in_valid   = 1'b0;
	logic                          in_ready;
	logic [DAY_W-1:0]              in_day     = '0;
	logic [MONTH_W-1:0]            in_month   = '0;
	logic [YEAR_W-1:0]             in_year    = '0;
	logic signed [OFFSET_BITS-1:0] day_offset = '0;
	logic                          out_valid;
	logic                          out_ready  = 1'b0;
	logic [DAY_W-1:0]              out_day;
	logic [MONTH_W-1:0]            out_month;
	logic [YEAR_W-1:0]             out_year;
	logic                          range_flag;
	logic                          bad_date;

	// Predicted results that are still waiting for their output transaction, oldest first.
	shifted_date_t shifted_dates_due[$];
	int            mismatch_count = 0;
	int            quiet_cycles   = 0;
	int            stall_left     = 0;
	// While calm is set, neither side starts a new gap. This gives back-to-back stretches.
	bit            calm           = 1'b0;

	calendar_date_shift_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_day     (in_day),
		.in_month   (in_month),
		.in_year    (in_year),
		.day_offset (day_offset),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_day    (out_day),
		.out_month  (out_month),
		.out_year   (out_year),
		.range_flag (range_flag),
		.bad_date   (bad_date)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Calendar arithmetic for the predictor. Dates are turned into a day
	// number counted from 1 January of year 1. The offset is added and the
	// sum is clamped to the supported span. The sum is then turned back
	// into a date.
	// ------------------------------------------------------------------

	// A year is a leap year if it is divisible by 4 but not by 100, or if it is divisible by 400.
	function automatic bit leap_year_of(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int days_in_month(input int m, input int y);
		case (m)
			2: begin
				return leap_year_of(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	// Days from 1 January of year 1 to 1 January of year y.
	function automatic longint days_before(input int y);
		longint p;
		p = y - 1;
		return p * 365 + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic longint day_number(input int d, input int m, input int y);
		longint n;
		n = days_before(y);
		for (int k = 1; k < m; k++)
			n += days_in_month(k, y);
		return n + d - 1;
	endfunction

	// The year is estimated from the mean Gregorian year length and then
	// corrected by a step or two in either direction.
	function automatic void date_of(input longint n, output int d, output int m, output int y);
		longint yy;
		longint rest;
		yy = (n * 400) / 146097 + 1;
		if (yy < 1)
			yy = 1;
		while (yy > 1 && days_before(int'(yy)) > n)
			yy--;
		while (days_before(int'(yy) + 1) <= n)
			yy++;
		rest = n - days_before(int'(yy));
		m = 1;
		while (m < 12 && rest >= days_in_month(m, int'(yy))) begin
			rest -= days_in_month(m, int'(yy));
			m++;
		end
		y = int'(yy);
		d = int'(rest) + 1;
	endfunction

	// Expected result for one input transaction.
	function automatic shifted_date_t shift_date(input logic [DAY_W-1:0] d_in,
		input logic [MONTH_W-1:0] m_in, input logic [YEAR_W-1:0] y_in,
		input logic signed [OFFSET_BITS-1:0] ofs);
		shifted_date_t r;
		int            d;
		int            m;
		int            y;
		longint        n;
		longint        last_n;
		d = d_in;
		m = m_in;
		y = y_in;
		r = '0;
		// An invalid date is returned as it came in, with only bad_date set.
		if (m < 1 || m > 12 || d == 0 || d > days_in_month(m, y) || y == 0 ||
			y > int'(YEAR_MAX)) begin
			r.day     = d_in;
			r.month   = m_in;
			r.year    = y_in;
			r.invalid = 1'b1;
			return r;
		end
		n      = day_number(d, m, y) + longint'(ofs);
		last_n = day_number(31, 12, int'(YEAR_MAX));
		// A shift that passes a limit date holds on that date. A shift that
		// lands exactly on it is an ordinary result.
		if (n < 0) begin
			n           = 0;
			r.range_hit = 1'b1;
		end else if (n > last_n) begin
			n           = last_n;
			r.range_hit = 1'b1;
		end
		date_of(n, d, m, y);
		r.day   = d[DAY_W-1:0];
		r.month = m[MONTH_W-1:0];
		r.year  = y[YEAR_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Flow control.
	// ------------------------------------------------------------------

	// Gap length: most gaps are a few cycles, and now and then one is long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	// The result side stalls at random. Over the core's long walk, the stalls
	// land on every phase of its work, including the cycle a result appears.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Offers one input transaction, after an optional gap, and returns at the
	// rising edge at which it is accepted. Valid is lowered only during a
	// gap. Back-to-back transactions keep it high.
	task automatic send_date(input int d, input int m, input int y, input int ofs);
		int gap;
		gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		in_day     <= DAY_W'(d);
		in_month   <= MONTH_W'(m);
		in_year    <= YEAR_W'(y);
		day_offset <= OFFSET_BITS'(ofs);
		do @(posedge clk); while (!in_ready);
	endtask

	// ------------------------------------------------------------------
	// Scoreboard and watchdog.
	// ------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [YEAR_W-1:0] want,
		input logic [YEAR_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// At each rising edge the result transaction is checked before a new
	// prediction is queued. The core registers its result, so any
	// result seen now belongs to an earlier input transaction.
	always @(posedge clk) begin
		shifted_date_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (shifted_dates_due.size() == 0) begin
					$display("%0t: result %0d-%0d-%0d arrived with none expected",
						$time, out_year, out_month, out_day);
					mismatch_count++;
				end else begin
					want = shifted_dates_due.pop_front();
					compare_field("out_day", want.day, out_day);
					compare_field("out_month", want.month, out_month);
					compare_field("out_year", want.year, out_year);
					compare_field("range_flag", want.range_hit, range_flag);
					compare_field("bad_date", want.invalid, bad_date);
				end
			end
			if (in_valid && in_ready)
				shifted_dates_due.push_back(shift_date(in_day, in_month, in_year, day_offset));

			// A hung handshake on either side ends the run.
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL calendar_date_shift_core");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Dates that must be flagged and passed through: a month out of range, a
	// day out of range for its month, Feb 29 in a century year that is not a
	// leap year, and a year of zero or above the limit. One item sets every bit
	// of the day, month and year inputs at once.
	task automatic test_invalid_dates();
		send_date(1, 0, 2000, 5);
		send_date(15, 13, 2020, -3);
		send_date(31, 15, 16383, 100);
		send_date(0, 6, 1987, 1);
		send_date(29, 2, 1900, 1);
		send_date(30, 2, 2000, -1);
		send_date(31, 4, 2021, 0);
		send_date(10, 7, 0, 12);
		send_date(1, 1, 10000, -1);
	endtask

	// Carries across February under all three parts of the leap rule, and
	// across the year boundary in both directions. A zero offset is included.
	task automatic test_leap_rules();
		send_date(28, 2, 2000, 1);
		send_date(28, 2, 1900, 1);
		send_date(1, 3, 2024, -1);
		send_date(1, 3, 2100, -1);
		send_date(31, 12, 1999, 1);
		send_date(1, 1, 2001, -1);
		send_date(15, 6, 2023, 0);
	endtask

	// Landing exactly on the first or the last date is a plain result.
	// Passing either date holds at the limit and sets range_flag.
	task automatic test_year_limits();
		send_date(30, 12, 9999, 1);
		send_date(2, 1, 1, -1);
		send_date(20, 12, 9999, 30);
		send_date(5, 1, 1, -10);
	endtask

	// Offsets of 65535 days: one runs past the end, one stays in range, and one starts at the first date.
	task automatic test_offset_extremes();
		send_date(1, 6, 9990, 65535);
		send_date(31, 12, 9999, -65535);
		send_date(1, 1, 1, -65535);
	endtask

	// Most items are valid dates with offsets of up to about two years, and
	// month-end days are favored. Some items sit near the year limits, some
	// are raw noise in day, month and year, and a rare one carries a very large
	// offset.
	task automatic test_random_walks(input int count);
		int d;
		int m;
		int y;
		int ofs;
		int pick;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 199);
			m    = $urandom_range(1, 12);
			if (pick >= 16 && pick < 36) begin
				if ($urandom_range(0, 1) == 1)
					y = $urandom_range(1, 3);
				else
					y = $urandom_range(int'(YEAR_MAX) - 2, int'(YEAR_MAX));
			end else begin
				y = $urandom_range(1, int'(YEAR_MAX));
			end
			d = ($urandom_range(0, 3) == 0) ? days_in_month(m, y) :
				$urandom_range(1, days_in_month(m, y));

			if (pick == 0) begin
				ofs = $urandom_range(8000, 65535);
				if ($urandom_range(0, 1) == 1)
					ofs = -ofs;
			end else if (pick < 16) begin
				d   = $urandom_range(0, 31);
				m   = $urandom_range(0, 15);
				y   = $urandom_range(0, 16383);
				ofs = $urandom_range(0, 1600) - 800;
			end else if (pick < 36) begin
				ofs = $urandom_range(0, 2400) - 1200;
			end else if ($urandom_range(0, 1) == 1) begin
				ofs = $urandom_range(0, 80) - 40;
			end else begin
				ofs = $urandom_range(0, 1600) - 800;
			end
			send_date(d, m, y, ofs);
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_invalid_dates();
		test_leap_rules();
		test_year_limits();
		test_offset_extremes();
		test_random_walks(RANDOM_ITEMS);

		// By the falling edge the last accepted transaction is already queued.
		// The drain loop below therefore cannot see an empty queue too early.
		@(negedge clk);
		in_valid <= 1'b0;
		while (shifted_dates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS calendar_date_shift_core");
		else
			$display("FAIL calendar_date_shift_core");
		$finish;
	end

endmodule
